// ===== rtl/kdl_pkg.sv =====
// Shared types and constants of the keyed deque list engine.
// Depends on nothing; used by kdl_free_map and keyed_deque_list_engine.
`default_nettype none

package kdl_pkg;

  localparam int POOL_DEPTH  = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  // slot address and link index (one extra code for the null link)
  localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IDX_W  = $clog2(POOL_DEPTH + 1);
  localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(POOL_DEPTH);

  localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH + 2 * IDX_W;

  typedef enum logic [3:0] {
    MODE_INS_HEAD   = 4'd0,
    MODE_INS_TAIL   = 4'd1,
    MODE_FIND_FIRST = 4'd2,
    MODE_FIND_LAST  = 4'd3,
    MODE_POP_HEAD   = 4'd4,
    MODE_POP_TAIL   = 4'd5,
    MODE_RM_FIRST   = 4'd6,
    MODE_RM_LAST    = 4'd7,
    MODE_RM_ALL     = 4'd8,
    MODE_CLEAR      = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LINK,
    ST_READ,
    ST_CHECK,
    ST_UNL_NEXT,
    ST_UNL_PREV,
    ST_DONE
  } state_t;

  // one pool slot as held in the node memory
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]       next;
    logic [IDX_W-1:0]       prev;
  } entry_t;

  // free map controls from the sequencer
  typedef struct packed {
    logic              alloc;
    logic [ADDR_W-1:0] alloc_idx;
    logic              release_one;
    logic [ADDR_W-1:0] release_idx;
    logic              release_all;
  } free_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/kdl_ram.sv =====
// Generic single-port-write, single-port-read RAM with bit write mask.
// Read data is registered. No package dependency.
`default_nettype none

module kdl_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [WIDTH-1:0]  wmask,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // masked write
  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) mem[waddr][i] <= wdata[i];
      end
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/kdl_free_map.sv =====
// Free slot map of the node pool with lowest-free-slot encoder.
// Depends on kdl_pkg.
`default_nettype none

module kdl_free_map (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire kdl_pkg::free_ctl_t       ctl,
  output logic                          has_free,
  output logic [kdl_pkg::ADDR_W-1:0]    free_idx
);

  logic [kdl_pkg::POOL_DEPTH-1:0] map_r, map_nxt;

  // lowest free slot
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = kdl_pkg::POOL_DEPTH - 1; i >= 0; i--) begin
      if (map_r[i]) begin
        has_free = 1'b1;
        free_idx = kdl_pkg::ADDR_W'(i);
      end
    end
  end

  // map update
  always_comb begin
    map_nxt = map_r;
    if (ctl.release_all) begin
      map_nxt = '1;
    end else begin
      if (ctl.alloc) map_nxt[ctl.alloc_idx] = 1'b0;
      if (ctl.release_one) map_nxt[ctl.release_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) map_r <= '1;
    else map_r <= map_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/keyed_deque_list_engine.sv =====
// Top level of the keyed deque list engine: request sequencer, node memory,
// free map and result register. Depends on kdl_pkg, kdl_ram, kdl_free_map.
`default_nettype none

// The engine keeps an ordered doubly linked list of key/value entries in a
// pool of kdl_pkg::POOL_DEPTH slots held in one node memory (one read, one
// masked write per cycle, read data registered). One request is worked at a
// time. Inserts write a free slot, if any, and on a non-empty list then hook
// the old end node to it; clear and unused modes go straight to the result.
// Pops take the end node as their match. Finds and removes walk the links
// one node per cycle from the head or tail; a match is unlinked by a write
// to its next node and then one to its previous node. Remove all walks the
// whole list and reads on from the node after each removed one; the node
// memory's single read port sets the walk rate. The result register lets the
// next request be taken while a result still waits on out_ready. No clearing
// pass is run after reset; the pool is empty at once.
module keyed_deque_list_engine (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [3:0]                          in_mode,
  input  wire logic signed [kdl_pkg::KEY_WIDTH-1:0] in_key,
  input  wire logic [kdl_pkg::VALUE_WIDTH-1:0]     in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [1:0]                               out_status,
  output logic [kdl_pkg::VALUE_WIDTH-1:0]          out_found_value
);

  localparam int IW = kdl_pkg::IDX_W;
  localparam int AW = kdl_pkg::ADDR_W;

  kdl_pkg::state_t state_r, state_nxt;

  logic [3:0]                      op_r, op_nxt;
  logic [kdl_pkg::KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [kdl_pkg::VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                            fwd_r, fwd_nxt;
  logic [IW-1:0]                   cur_r, cur_nxt;
  logic [IW-1:0]                   nx_r, nx_nxt;
  logic [IW-1:0]                   pv_r, pv_nxt;
  logic [IW-1:0]                   head_r, head_nxt;
  logic [IW-1:0]                   tail_r, tail_nxt;
  logic [1:0]                      res_status_r, res_status_nxt;
  logic [kdl_pkg::VALUE_WIDTH-1:0] res_found_r, res_found_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic [kdl_pkg::VALUE_WIDTH-1:0] out_found_r, out_found_nxt;

  // node memory port signals
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  kdl_pkg::entry_t       ram_wdata, ram_wmask, rd;
  logic [kdl_pkg::ENTRY_W-1:0] ram_rdata;

  kdl_pkg::free_ctl_t    free_ctl;
  logic                  has_free;
  logic [AW-1:0]         free_idx;

  kdl_ram #(
    .DEPTH (kdl_pkg::POOL_DEPTH),
    .WIDTH (kdl_pkg::ENTRY_W),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .wmask(ram_wmask),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = ram_rdata;

  kdl_free_map u_free (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (free_ctl),
    .has_free(has_free),
    .free_idx(free_idx)
  );

  // decoded request and walk conditions
  logic is_find, is_pop, is_rmall, is_ins_head, start_head, hit;
  logic cur_nil, step_nil, out_free;
  logic [IW-1:0] step_link, ins_old;
  logic [1:0] miss_status;

  assign is_find     = (op_r == kdl_pkg::MODE_FIND_FIRST) || (op_r == kdl_pkg::MODE_FIND_LAST);
  assign is_pop      = (op_r == kdl_pkg::MODE_POP_HEAD) || (op_r == kdl_pkg::MODE_POP_TAIL);
  assign is_rmall    = (op_r == kdl_pkg::MODE_RM_ALL);
  assign is_ins_head = (op_r == kdl_pkg::MODE_INS_HEAD);
  assign start_head  = (in_mode == kdl_pkg::MODE_FIND_FIRST) ||
                       (in_mode == kdl_pkg::MODE_POP_HEAD) ||
                       (in_mode == kdl_pkg::MODE_RM_FIRST) ||
                       (in_mode == kdl_pkg::MODE_RM_ALL);
  assign hit         = is_pop || (rd.key == key_r);
  assign step_link   = fwd_r ? rd.next : rd.prev;
  assign cur_nil     = (cur_r == kdl_pkg::NIL_IDX);
  assign step_nil    = (step_link == kdl_pkg::NIL_IDX);
  assign ins_old     = is_ins_head ? head_r : tail_r;
  assign miss_status = is_rmall ? kdl_pkg::STAT_OK : kdl_pkg::STAT_NOT_FOUND;
  assign out_free    = !out_valid_r || out_ready;

  assign in_ready        = (state_r == kdl_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kdl_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            kdl_pkg::MODE_INS_HEAD, kdl_pkg::MODE_INS_TAIL: state_nxt = kdl_pkg::ST_INS;
            kdl_pkg::MODE_FIND_FIRST, kdl_pkg::MODE_FIND_LAST,
            kdl_pkg::MODE_POP_HEAD, kdl_pkg::MODE_POP_TAIL,
            kdl_pkg::MODE_RM_FIRST, kdl_pkg::MODE_RM_LAST,
            kdl_pkg::MODE_RM_ALL: state_nxt = kdl_pkg::ST_READ;
            default: state_nxt = kdl_pkg::ST_DONE;
          endcase
        end
      end
      kdl_pkg::ST_INS: begin
        if (!has_free || ins_old == kdl_pkg::NIL_IDX) state_nxt = kdl_pkg::ST_DONE;
        else state_nxt = kdl_pkg::ST_INS_LINK;
      end
      kdl_pkg::ST_INS_LINK: state_nxt = kdl_pkg::ST_DONE;
      kdl_pkg::ST_READ: begin
        state_nxt = cur_nil ? kdl_pkg::ST_DONE : kdl_pkg::ST_CHECK;
      end
      kdl_pkg::ST_CHECK: begin
        if (hit) state_nxt = is_find ? kdl_pkg::ST_DONE : kdl_pkg::ST_UNL_NEXT;
        else if (step_nil) state_nxt = kdl_pkg::ST_DONE;
      end
      kdl_pkg::ST_UNL_NEXT: state_nxt = kdl_pkg::ST_UNL_PREV;
      kdl_pkg::ST_UNL_PREV: begin
        state_nxt = is_rmall ? kdl_pkg::ST_READ : kdl_pkg::ST_DONE;
      end
      kdl_pkg::ST_DONE: begin
        if (out_free) state_nxt = kdl_pkg::ST_IDLE;
      end
      default: state_nxt = kdl_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory and free map controls
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    fwd_nxt        = fwd_r;
    cur_nxt        = cur_r;
    nx_nxt         = nx_r;
    pv_nxt         = pv_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r[AW-1:0];
    ram_wdata      = '0;
    ram_wmask      = '0;
    ram_raddr      = cur_r[AW-1:0];
    free_ctl       = '0;

    case (state_r)
      kdl_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_mode;
          key_nxt        = in_key;
          val_nxt        = in_value;
          fwd_nxt        = start_head;
          cur_nxt        = start_head ? head_r : tail_r;
          res_found_nxt  = '0;
          res_status_nxt = kdl_pkg::STAT_NOT_FOUND;
          if (in_mode == kdl_pkg::MODE_CLEAR) begin
            res_status_nxt       = kdl_pkg::STAT_OK;
            free_ctl.release_all = 1'b1;
            head_nxt             = kdl_pkg::NIL_IDX;
            tail_nxt             = kdl_pkg::NIL_IDX;
          end
        end
      end
      kdl_pkg::ST_INS: begin
        if (!has_free) begin
          res_status_nxt = kdl_pkg::STAT_FULL;
        end else begin
          res_status_nxt     = kdl_pkg::STAT_OK;
          free_ctl.alloc     = 1'b1;
          free_ctl.alloc_idx = free_idx;
          cur_nxt            = IW'(free_idx);
          pv_nxt             = ins_old;
          ram_we             = 1'b1;
          ram_waddr          = free_idx;
          ram_wmask          = '1;
          ram_wdata.key      = key_r;
          ram_wdata.value    = val_r;
          ram_wdata.next     = is_ins_head ? head_r : kdl_pkg::NIL_IDX;
          ram_wdata.prev     = is_ins_head ? kdl_pkg::NIL_IDX : tail_r;
          if (is_ins_head) begin
            head_nxt = IW'(free_idx);
            if (tail_r == kdl_pkg::NIL_IDX) tail_nxt = IW'(free_idx);
          end else begin
            tail_nxt = IW'(free_idx);
            if (head_r == kdl_pkg::NIL_IDX) head_nxt = IW'(free_idx);
          end
        end
      end
      kdl_pkg::ST_INS_LINK: begin
        // hook the old end node to the new slot
        ram_we    = 1'b1;
        ram_waddr = pv_r[AW-1:0];
        if (is_ins_head) begin
          ram_wdata.prev = cur_r;
          ram_wmask.prev = '1;
        end else begin
          ram_wdata.next = cur_r;
          ram_wmask.next = '1;
        end
      end
      kdl_pkg::ST_READ: begin
        if (cur_nil) res_status_nxt = miss_status;
      end
      kdl_pkg::ST_CHECK: begin
        if (hit) begin
          if (is_find) begin
            res_status_nxt = kdl_pkg::STAT_OK;
            res_found_nxt  = rd.value;
          end else begin
            nx_nxt = rd.next;
            pv_nxt = rd.prev;
            if (!is_rmall) res_found_nxt = rd.value;
            if (head_r == cur_r) head_nxt = rd.next;
            if (tail_r == cur_r) tail_nxt = rd.prev;
            free_ctl.release_one = 1'b1;
            free_ctl.release_idx = cur_r[AW-1:0];
          end
        end else if (step_nil) begin
          res_status_nxt = miss_status;
        end else begin
          // chase the link straight into the next read
          cur_nxt   = step_link;
          ram_raddr = step_link[AW-1:0];
        end
      end
      kdl_pkg::ST_UNL_NEXT: begin
        if (nx_r != kdl_pkg::NIL_IDX) begin
          ram_we         = 1'b1;
          ram_waddr      = nx_r[AW-1:0];
          ram_wdata.prev = pv_r;
          ram_wmask.prev = '1;
        end
      end
      kdl_pkg::ST_UNL_PREV: begin
        if (pv_r != kdl_pkg::NIL_IDX) begin
          ram_we         = 1'b1;
          ram_waddr      = pv_r[AW-1:0];
          ram_wdata.next = nx_r;
          ram_wmask.next = '1;
        end
        if (is_rmall) cur_nxt = nx_r;
        else res_status_nxt = kdl_pkg::STAT_OK;
      end
      kdl_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kdl_pkg::ST_IDLE;
      head_r      <= kdl_pkg::NIL_IDX;
      tail_r      <= kdl_pkg::NIL_IDX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    fwd_r        <= fwd_nxt;
    cur_r        <= cur_nxt;
    nx_r         <= nx_nxt;
    pv_r         <= pv_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
  end

endmodule

`default_nettype wire
